@@ rtl/core/crke_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crke_pkg
// Shared types, constants and helpers for the composite row key encoder.
// ----------------------------------------------------------------------------
package crke_pkg;

  localparam logic [31:0] FnvBasis = 32'd2166136261;
  localparam logic [31:0] FnvPrime = 32'd16777619;
  localparam logic [31:0] Golden   = 32'h9e3779b9;
  localparam logic [5:0]  FullBits = 6'd32;

  typedef enum logic [3:0] {
    KIND_NULL      = 4'd0,
    KIND_INT64     = 4'd1,
    KIND_UINT64    = 4'd2,
    KIND_INT32     = 4'd3,
    KIND_UINT32    = 4'd4,
    KIND_STRING    = 4'd5,
    KIND_BINARY    = 4'd6,
    KIND_DOUBLE    = 4'd7,
    KIND_TIMESTAMP = 4'd8,
    KIND_OTHER     = 4'd9
  } kind_e;

  typedef struct packed {
    logic        role;
    logic [3:0]  kind;
    logic [63:0] value;
    logic        has_byte;
    logic        col_last;
    logic        row_last;
  } item_t;

  // Bits kept per clustering column: 32 / count, zero when count is zero.
  function automatic logic [5:0] per_column_bits(input logic [5:0] count);
    logic [5:0] bits;
    bits = 6'd0;
    case (count) inside
      6'd1:            bits = 6'd32;
      6'd2:            bits = 6'd16;
      6'd3:            bits = 6'd10;
      6'd4:            bits = 6'd8;
      6'd5:            bits = 6'd6;
      6'd6:            bits = 6'd5;
      [6'd7:6'd8]:     bits = 6'd4;
      [6'd9:6'd10]:    bits = 6'd3;
      [6'd11:6'd16]:   bits = 6'd2;
      [6'd17:6'd32]:   bits = 6'd1;
      default:         bits = 6'd0;
    endcase
    return bits;
  endfunction

  function automatic logic [31:0] hash_combine(input logic [31:0] h, input logic [31:0] v);
    return h ^ (v + Golden + (h << 6) + (h >> 2));
  endfunction

endpackage

@@ rtl/core/crke_in_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crke_in_reg
// Input register: captures one column item and holds it until the key core
// consumes it.
// ----------------------------------------------------------------------------
module crke_in_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  crke_pkg::item_t  item_i,
  input  logic             advance_i,
  output logic             item_valid_o,
  output crke_pkg::item_t  item_o
);

  logic            valid_q, valid_d;
  crke_pkg::item_t item_q;

  assign in_ready_o = !valid_q || advance_i;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

@@ rtl/core/crke_key_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crke_key_core
// Running row state, per-item column hashing and clustering packing, and the
// row key output register.
// ----------------------------------------------------------------------------
module crke_key_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  input  crke_pkg::item_t  item_i,
  input  logic [5:0]       per_bits_i,
  output logic             advance_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [63:0]      row_key_o
);

  logic [31:0] partition_hash_q, partition_hash_d;
  logic [31:0] cluster_accum_q, cluster_accum_d;
  logic [5:0]  bits_left_q, bits_left_d;
  logic [31:0] byte_hash_q, byte_hash_d;
  logic [31:0] string_prefix_q, string_prefix_d;
  logic [2:0]  prefix_bytes_q, prefix_bytes_d;
  logic        out_valid_q, out_valid_d;
  logic [63:0] row_key_q;

  logic        is_str, close_col;
  logic [7:0]  byte_val;
  logic [31:0] bh_new, sp_new, vhash, scode, ph_close, ca_close;
  logic [2:0]  pb_new, pad;
  logic [5:0]  bits, bl_close;
  logic [63:0] sp_shift, top, acc;

  // Stall only a row-ending item while the previous key is still waiting.
  assign advance_o = item_valid_i && (!item_i.row_last || !out_valid_q || out_ready_i);

  always_comb begin
    is_str   = (item_i.kind == crke_pkg::KIND_STRING) || (item_i.kind == crke_pkg::KIND_BINARY);
    byte_val = item_i.value[7:0];
    bh_new   = byte_hash_q;
    sp_new   = string_prefix_q;
    pb_new   = prefix_bytes_q;
    if (is_str && item_i.has_byte) begin
      bh_new = (byte_hash_q ^ {{24{byte_val[7]}}, byte_val}) * crke_pkg::FnvPrime;
      if (prefix_bytes_q < 3'd4) begin
        sp_new = {string_prefix_q[23:0], byte_val};
        pb_new = prefix_bytes_q + 3'd1;
      end
    end
    close_col = !is_str || item_i.col_last || item_i.row_last;

    case (item_i.kind)
      crke_pkg::KIND_INT64, crke_pkg::KIND_UINT64,
      crke_pkg::KIND_INT32, crke_pkg::KIND_UINT32: vhash = item_i.value[31:0];
      crke_pkg::KIND_STRING, crke_pkg::KIND_BINARY: vhash = bh_new;
      crke_pkg::KIND_DOUBLE: vhash = item_i.value[31:0] ^ item_i.value[63:32];
      default: vhash = 32'd0;
    endcase

    pad      = (pb_new < 3'd4) ? (3'd4 - pb_new) : 3'd0;
    sp_shift = {32'd0, sp_new} << {pad, 3'b000};
    case (item_i.kind)
      crke_pkg::KIND_INT64, crke_pkg::KIND_TIMESTAMP:
        scode = {~item_i.value[63], item_i.value[62:32]};
      crke_pkg::KIND_UINT64: scode = item_i.value[63:32];
      crke_pkg::KIND_INT32:  scode = {~item_i.value[31], item_i.value[30:0]};
      crke_pkg::KIND_UINT32: scode = item_i.value[31:0];
      crke_pkg::KIND_STRING: scode = sp_shift[31:0];
      default:               scode = 32'd0;
    endcase

    bits     = (per_bits_i < bits_left_q) ? per_bits_i : bits_left_q;
    top      = {32'd0, scode} >> (crke_pkg::FullBits - bits);
    acc      = ({32'd0, cluster_accum_q} << bits) | top;
    ph_close = partition_hash_q;
    ca_close = cluster_accum_q;
    bl_close = bits_left_q;
    if (!item_i.role) begin
      ph_close = crke_pkg::hash_combine(partition_hash_q, vhash);
    end else if (bits != 6'd0) begin
      ca_close = acc[31:0];
      bl_close = bits_left_q - bits;
    end
  end

  always_comb begin
    partition_hash_d = partition_hash_q;
    cluster_accum_d  = cluster_accum_q;
    bits_left_d      = bits_left_q;
    byte_hash_d      = byte_hash_q;
    string_prefix_d  = string_prefix_q;
    prefix_bytes_d   = prefix_bytes_q;
    out_valid_d      = out_valid_q && !out_ready_i;
    if (advance_o) begin
      if (close_col) begin
        partition_hash_d = ph_close;
        cluster_accum_d  = ca_close;
        bits_left_d      = bl_close;
        byte_hash_d      = crke_pkg::FnvBasis;
        string_prefix_d  = 32'd0;
        prefix_bytes_d   = 3'd0;
      end else begin
        byte_hash_d      = bh_new;
        string_prefix_d  = sp_new;
        prefix_bytes_d   = pb_new;
      end
      if (item_i.row_last) begin
        partition_hash_d = 32'd0;
        cluster_accum_d  = 32'd0;
        bits_left_d      = crke_pkg::FullBits;
        out_valid_d      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partition_hash_q <= 32'd0;
      cluster_accum_q  <= 32'd0;
      bits_left_q      <= crke_pkg::FullBits;
      byte_hash_q      <= crke_pkg::FnvBasis;
      string_prefix_q  <= 32'd0;
      prefix_bytes_q   <= 3'd0;
      out_valid_q      <= 1'b0;
    end else begin
      partition_hash_q <= partition_hash_d;
      cluster_accum_q  <= cluster_accum_d;
      bits_left_q      <= bits_left_d;
      byte_hash_q      <= byte_hash_d;
      string_prefix_q  <= string_prefix_d;
      prefix_bytes_q   <= prefix_bytes_d;
      out_valid_q      <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && item_i.row_last) begin
      row_key_q <= {ph_close, ca_close};
    end
  end

  assign out_valid_o = out_valid_q;
  assign row_key_o   = row_key_q;

`ifndef SYNTH
  a_bits_left_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_left_q <= crke_pkg::FullBits)
    else $error("bits_left out of range");

  a_prefix_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prefix_bytes_q <= 3'd4)
    else $error("prefix byte count out of range");

  a_clear_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prefix_bytes_q == 3'd0 |-> byte_hash_q == crke_pkg::FnvBasis && string_prefix_q == 32'd0)
    else $error("string state not cleared");

  a_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_o && item_i.row_last |=> out_valid_q && bits_left_q == crke_pkg::FullBits
      && partition_hash_q == 32'd0 && cluster_accum_q == 32'd0)
    else $error("row end did not emit key and reset state");
`endif

endmodule

@@ rtl/core/composite_row_key_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// composite_row_key_encoder
// Builds one 64-bit row key per row from streamed column items.
// ----------------------------------------------------------------------------
// Usage:
//   Column items enter on the in channel (valid/ready), one transaction per
//   numeric column value or per string/binary byte. Partition columns fold
//   into a 32-bit hash, clustering columns pack order-preserving prefixes.
//   An item with row_last set produces one row_key transaction on the out
//   channel; other items produce none.
//   The cfg channel (always ready) sets clustering_count; write it only
//   while no row is in flight.
// Timing:
//   One item per cycle sustained while no row-ending item is held back by a
//   waiting key. An item is registered in the input register, then a single
//   pass of hash and pack logic updates the row state; the key is registered
//   in the output register as the row-ending item leaves the input register.
// Reset:
//   Clears row state, the count register and both valid flags.
// Back-pressure:
//   While a key waits on out_ready_i, items that do not end a row keep
//   flowing; the next row-ending item holds in the input register.
// ----------------------------------------------------------------------------
module composite_row_key_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [5:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        role_i,
  input  logic [3:0]  kind_i,
  input  logic [63:0] value_i,
  input  logic        has_byte_i,
  input  logic        col_last_i,
  input  logic        row_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] row_key_o
);

  logic [5:0]      per_bits_q;
  crke_pkg::item_t in_item, reg_item;
  logic            reg_valid, advance;

  assign cfg_ready_o = 1'b1;

  // Hold the per-column bit count rather than the raw count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      per_bits_q <= 6'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      per_bits_q <= crke_pkg::per_column_bits(cfg_data_i);
    end
  end

  assign in_item = '{role: role_i, kind: kind_i, value: value_i, has_byte: has_byte_i,
                     col_last: col_last_i, row_last: row_last_i};

  crke_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .item_i       (in_item),
    .advance_i    (advance),
    .item_valid_o (reg_valid),
    .item_o       (reg_item)
  );

  crke_key_core u_key_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (reg_valid),
    .item_i       (reg_item),
    .per_bits_i   (per_bits_q),
    .advance_o    (advance),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .row_key_o    (row_key_o)
  );

endmodule

@@ tb/row_key_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_key_checker
// Watches the cfg, in and out channels of the row key encoder, folds every
// accepted column item into its own copy of the row state, queues the key
// each row end should produce and compares it with the next key accepted.
// ----------------------------------------------------------------------------
module row_key_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [5:0]  cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        role_i,
  input  logic [3:0]  kind_i,
  input  logic [63:0] value_i,
  input  logic        has_byte_i,
  input  logic        col_last_i,
  input  logic        row_last_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [63:0] row_key_i,
  output int          mismatch_count_o,
  output int          keys_waiting_o
);

  logic [5:0]  clus_count;
  logic [31:0] part_hash;
  logic [31:0] clus_prefix;
  logic [5:0]  clus_bits_left;
  logic [31:0] fnv_state;
  logic [31:0] str_head;
  logic [2:0]  str_head_len;
  logic [63:0] expected_keys[$];
  int          mismatches;

  assign mismatch_count_o = mismatches;

  function automatic logic [31:0] golden_mix(input logic [31:0] h, input logic [31:0] v);
    return h ^ (v + crke_pkg::Golden + (h << 6) + (h >> 2));
  endfunction

  function automatic logic [31:0] column_hash(input logic [3:0] kind, input logic [63:0] v);
    case (kind)
      crke_pkg::KIND_INT64, crke_pkg::KIND_UINT64,
      crke_pkg::KIND_INT32, crke_pkg::KIND_UINT32: return v[31:0];
      crke_pkg::KIND_STRING, crke_pkg::KIND_BINARY: return fnv_state;
      crke_pkg::KIND_DOUBLE: return v[31:0] ^ v[63:32];
      default: return 32'd0;
    endcase
  endfunction

  function automatic logic [31:0] order_code(input logic [3:0] kind, input logic [63:0] v);
    logic [63:0] padded;
    padded = 64'd0;
    case (kind)
      crke_pkg::KIND_INT64, crke_pkg::KIND_TIMESTAMP: return v[63:32] ^ 32'h8000_0000;
      crke_pkg::KIND_UINT64: return v[63:32];
      crke_pkg::KIND_INT32: return v[31:0] ^ 32'h8000_0000;
      crke_pkg::KIND_UINT32: return v[31:0];
      crke_pkg::KIND_STRING: begin
        // pad short prefixes with zero bytes on the right
        padded = {32'd0, str_head} << (8 * (4 - int'(str_head_len)));
        return padded[31:0];
      end
      default: return 32'd0;
    endcase
  endfunction

  task automatic clear_string_state();
    fnv_state    = crke_pkg::FnvBasis;
    str_head     = 32'd0;
    str_head_len = 3'd0;
  endtask

  task automatic clear_row_state();
    part_hash      = 32'd0;
    clus_prefix    = 32'd0;
    clus_bits_left = 6'd32;
    clear_string_state();
  endtask

  task automatic close_column(input logic role, input logic [3:0] kind, input logic [63:0] v);
    int          per;
    int          bits;
    logic [63:0] top;
    logic [63:0] acc;
    if (!role) begin
      part_hash = golden_mix(part_hash, column_hash(kind, v));
    end else if (clus_count != 6'd0) begin
      per  = 32 / int'(clus_count);
      bits = (per < int'(clus_bits_left)) ? per : int'(clus_bits_left);
      if (bits > 0) begin
        top            = {32'd0, order_code(kind, v)} >> (32 - bits);
        acc            = ({32'd0, clus_prefix} << bits) | top;
        clus_prefix    = acc[31:0];
        clus_bits_left = clus_bits_left - 6'(bits);
      end
    end
    clear_string_state();
  endtask

  task automatic fold_item();
    logic [7:0]  b;
    logic [31:0] sx;
    logic [63:0] key;
    if (kind_i == crke_pkg::KIND_STRING || kind_i == crke_pkg::KIND_BINARY) begin
      if (has_byte_i) begin
        b         = value_i[7:0];
        sx        = {{24{b[7]}}, b};
        fnv_state = (fnv_state ^ sx) * crke_pkg::FnvPrime;
        if (str_head_len < 3'd4) begin
          str_head     = {str_head[23:0], b};
          str_head_len = str_head_len + 3'd1;
        end
      end
      // a row end also closes an open string
      if (col_last_i || row_last_i) close_column(role_i, kind_i, value_i);
    end else begin
      close_column(role_i, kind_i, value_i);
    end
    if (row_last_i) begin
      key = {part_hash, clus_prefix};
      expected_keys.insert(expected_keys.size(), key);
      clear_row_state();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic [63:0] want;
    if (!rst_ni) begin
      clus_count = 6'd0;
      clear_row_state();
      expected_keys.delete();
      mismatches = 0;
      keys_waiting_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) clus_count = cfg_data_i;
      if (out_valid_i && out_ready_i) begin
        if (expected_keys.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected row_key %h", row_key_i);
        end else begin
          want = expected_keys.pop_front();
          if (row_key_i !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("row_key mismatch: expected %h actual %h", want, row_key_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) fold_item();
      keys_waiting_o <= expected_keys.size();
    end
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the composite row key encoder: a directed set of rows over
// every kind and the string corner cases, then random rows under a range of
// clustering counts, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;

  localparam int          CycleLimit  = 200000;
  localparam int          PhaseItems  = 70;
  localparam logic [3:0]  KindUnknown = 4'd15;  // highest unassigned kind code
  localparam logic [63:0] AllOnes     = 64'hFFFF_FFFF_FFFF_FFFF;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [5:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        role_i;
  logic [3:0]  kind_i;
  logic [63:0] value_i;
  logic        has_byte_i;
  logic        col_last_i;
  logic        row_last_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] row_key_o;

  int mismatch_count;
  int keys_waiting;
  int items_sent;
  bit steady;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  composite_row_key_encoder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .role_i      (role_i),
    .kind_i      (kind_i),
    .value_i     (value_i),
    .has_byte_i  (has_byte_i),
    .col_last_i  (col_last_i),
    .row_last_i  (row_last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .row_key_o   (row_key_o)
  );

  row_key_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .role_i           (role_i),
    .kind_i           (kind_i),
    .value_i          (value_i),
    .has_byte_i       (has_byte_i),
    .col_last_i       (col_last_i),
    .row_last_i       (row_last_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .row_key_i        (row_key_o),
    .mismatch_count_o (mismatch_count),
    .keys_waiting_o   (keys_waiting)
  );

  always @(posedge clk_i) out_ready_i <= steady || ($urandom_range(0, 99) >= 26);

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("Some tests failed");
    $finish;
  end

  task automatic push(input logic role, input logic [3:0] kind, input logic [63:0] value,
                      input logic has_byte, input logic col_last, input logic row_last);
    int gap;
    gap = 0;
    if (!steady) while ($urandom_range(0, 99) < 26) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    role_i     <= role;
    kind_i     <= kind;
    value_i    <= value;
    has_byte_i <= has_byte;
    col_last_i <= col_last;
    row_last_i <= row_last;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // Drop valid, let every key come out, then give the input register time to empty.
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (keys_waiting != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [5:0] count);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= count;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return AllOnes;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'($urandom_range(0, 255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [3:0] pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 4'($urandom_range(10, 15));
    if (r < 30) return crke_pkg::KIND_STRING;
    return 4'($urandom_range(0, 9));
  endfunction

  task automatic send_column(input logic role, input logic [3:0] kind, input bit end_row);
    int nbytes;
    bit last;
    if (kind == crke_pkg::KIND_STRING || kind == crke_pkg::KIND_BINARY) begin
      nbytes = $urandom_range(0, 6);
      if (nbytes == 0) begin
        push(role, kind, {$urandom, $urandom}, 1'b0, 1'b1, end_row);
      end else begin
        for (int i = 0; i < nbytes; i++) begin
          last = (i == nbytes - 1);
          // some items carry no byte; some rows end without closing the string
          push(role, kind, {$urandom, $urandom}, $urandom_range(0, 9) != 0,
               last && !(end_row && $urandom_range(0, 1)), end_row && last);
        end
      end
    end else begin
      push(role, kind, pick_value(), 1'($urandom), 1'($urandom), end_row);
    end
  endtask

  task automatic send_row();
    int ncols;
    ncols = $urandom_range(1, 6);
    for (int c = 0; c < ncols; c++) send_column(1'($urandom), pick_kind(), c == ncols - 1);
  endtask

  initial begin
    logic [5:0] counts[10];
    counts = '{6'd0, 6'd32, 6'd2, 6'd3, 6'd63, 6'd5, 6'd33, 6'd7, 6'd4, 6'd1};
    items_sent  = 0;
    steady      = 1'b0;
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= 6'd0;
    in_valid_i  <= 1'b0;
    role_i      <= 1'b0;
    kind_i      <= crke_pkg::KIND_NULL;
    value_i     <= 64'd0;
    has_byte_i  <= 1'b0;
    col_last_i  <= 1'b0;
    row_last_i  <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_count(6'd1);
    // partition kinds, sign-extended string bytes, clustering at full width
    push(1'b0, crke_pkg::KIND_NULL, AllOnes, 1'b1, 1'b1, 1'b0);
    push(1'b0, crke_pkg::KIND_INT64, AllOnes, 1'b0, 1'b0, 1'b0);
    push(1'b0, crke_pkg::KIND_DOUBLE, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b1, 1'b0);
    push(1'b0, crke_pkg::KIND_STRING, 64'h80, 1'b1, 1'b0, 1'b0);
    push(1'b0, crke_pkg::KIND_STRING, 64'h7F, 1'b1, 1'b0, 1'b0);
    push(1'b0, crke_pkg::KIND_STRING, 64'hFF, 1'b1, 1'b1, 1'b0);
    push(1'b1, crke_pkg::KIND_INT64, 64'd0, 1'b0, 1'b1, 1'b1);
    // empty binary, zero-hash kinds, row end inside a short string
    push(1'b0, crke_pkg::KIND_BINARY, 64'd0, 1'b0, 1'b1, 1'b0);
    push(1'b0, crke_pkg::KIND_TIMESTAMP, AllOnes, 1'b1, 1'b1, 1'b0);
    push(1'b0, crke_pkg::KIND_OTHER, AllOnes, 1'b1, 1'b1, 1'b0);
    push(1'b0, KindUnknown, AllOnes, 1'b1, 1'b1, 1'b0);
    push(1'b1, crke_pkg::KIND_STRING, 64'h61, 1'b1, 1'b0, 1'b0);
    push(1'b1, crke_pkg::KIND_STRING, 64'h62, 1'b1, 1'b0, 1'b1);
    // extra clustering columns once the prefix is full
    push(1'b1, crke_pkg::KIND_UINT64, AllOnes, 1'b1, 1'b0, 1'b0);
    push(1'b1, crke_pkg::KIND_INT32, 64'd0, 1'b0, 1'b1, 1'b0);
    push(1'b1, crke_pkg::KIND_UINT32, AllOnes, 1'b0, 1'b0, 1'b0);
    push(1'b0, crke_pkg::KIND_UINT32, 64'h8000_0000_FFFF_FFFF, 1'b0, 1'b0, 1'b0);
    push(1'b0, crke_pkg::KIND_INT32, 64'hFFFF_FFFF_8000_0000, 1'b1, 1'b1, 1'b0);
    push(1'b0, crke_pkg::KIND_UINT64, 64'h7FFF_FFFF_0000_0001, 1'b0, 1'b0, 1'b0);
    push(1'b1, crke_pkg::KIND_DOUBLE, AllOnes, 1'b0, 1'b0, 1'b1);
    // string longer than the four-byte prefix
    for (int i = 0; i < 5; i++)
      push(1'b1, crke_pkg::KIND_STRING, 64'(8'h41 + i), 1'b1, i == 4, 1'b0);
    push(1'b1, crke_pkg::KIND_NULL, 64'd0, 1'b0, 1'b0, 1'b1);
    // row made of one empty string item
    push(1'b1, crke_pkg::KIND_STRING, 64'd0, 1'b0, 1'b0, 1'b1);

    for (int p = 0; p < 11; p++) begin
      wait_quiet();
      write_count(p < 10 ? counts[p] : 6'($urandom_range(0, 63)));
      steady = (p == 4);
      while (items_sent < 27 + (p + 1) * PhaseItems) send_row();
    end
    steady = 1'b0;

    wait_quiet();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && keys_waiting == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ composite_row_key_encoder.f @@
rtl/core/crke_pkg.sv
rtl/core/crke_in_reg.sv
rtl/core/crke_key_core.sv
rtl/core/composite_row_key_encoder.sv
tb/row_key_checker.sv
tb/tb.sv
